/* sv/lbps_pkg.sv */
// ----------------------------------------------------------------------------
// lbps_pkg
// Shared types, codes and phase tables for the LED blink pattern sequencer.
// ----------------------------------------------------------------------------
package lbps_pkg;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int MODE_W     = 3;
    localparam int PATTERN_W  = 3;
    localparam int PHASE_W    = 3;
    localparam int PH_TIME_W  = 10;
    localparam int ALERT_W    = 12;
    localparam int PHASE_CNT_W = 4;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_ALERT_LEN = 1'b0;

    // Defaults
    localparam int MAX_PHASES_DEFAULT = 6;
    localparam logic [ALERT_W-1:0] ALERT_LEN_RESET = 12'd1500;

    // Pattern codes
    localparam logic [PATTERN_W-1:0] PAT_WAITING = 3'd0;
    localparam logic [PATTERN_W-1:0] PAT_IDLE_A   = 3'd1;
    localparam logic [PATTERN_W-1:0] PAT_IDLE_B   = 3'd2;
    localparam logic [PATTERN_W-1:0] PAT_ACTIVE_A = 3'd3;
    localparam logic [PATTERN_W-1:0] PAT_ACTIVE_B = 3'd4;
    localparam logic [PATTERN_W-1:0] PAT_ALERT   = 3'd5;

    // Reset phase: first waiting phase
    localparam logic [PH_TIME_W-1:0] RESET_PH_TIME = 10'd80;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK     = 2'd0,
        OP_SET_MODE = 2'd1,
        OP_ALERT    = 2'd2,
        OP_UNUSED   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [MODE_W-1:0]   mode;
    } t_in_item;

    typedef struct packed {
        logic                 led_on;
        logic [PATTERN_W-1:0] shown_pattern;
        logic [PHASE_W-1:0]   phase_number;
        logic                 alert_active;
    } t_out_item;

    typedef struct packed {
        logic                 lit;
        logic [PH_TIME_W-1:0] ms;
    } t_phase;

    // Number of phases in each pattern
    function automatic logic [PHASE_CNT_W-1:0] pat_count(input logic [PATTERN_W-1:0] pat);
        logic [PHASE_CNT_W-1:0] cnt;
        case (pat)
            PAT_WAITING:  cnt = 4'd2;
            PAT_IDLE_A:   cnt = 4'd4;
            PAT_IDLE_B:   cnt = 4'd6;
            PAT_ACTIVE_A: cnt = 4'd2;
            PAT_ACTIVE_B: cnt = 4'd4;
            PAT_ALERT:    cnt = 4'd6;
            default:      cnt = 4'd2;
        endcase
        return cnt;
    endfunction

    // Level and duration of one phase; unused slots are dark and zero long
    function automatic t_phase phase_entry(input logic [PATTERN_W-1:0] pat,
                                           input logic [PHASE_W-1:0]   idx);
        t_phase ph;
        ph = '{lit: 1'b0, ms: '0};
        case (pat)
            PAT_IDLE_A: begin
                case (idx)
                    3'd0:    ph = '{lit: 1'b1, ms: 10'd70};
                    3'd1:    ph = '{lit: 1'b0, ms: 10'd130};
                    3'd2:    ph = '{lit: 1'b1, ms: 10'd70};
                    3'd3:    ph = '{lit: 1'b0, ms: 10'd730};
                    default: ph = '{lit: 1'b0, ms: '0};
                endcase
            end
            PAT_IDLE_B: begin
                case (idx)
                    3'd0, 3'd2, 3'd4: ph = '{lit: 1'b1, ms: 10'd70};
                    3'd1, 3'd3:       ph = '{lit: 1'b0, ms: 10'd100};
                    3'd5:             ph = '{lit: 1'b0, ms: 10'd590};
                    default:          ph = '{lit: 1'b0, ms: '0};
                endcase
            end
            PAT_ACTIVE_A: begin
                case (idx)
                    3'd0:    ph = '{lit: 1'b1, ms: 10'd900};
                    3'd1:    ph = '{lit: 1'b0, ms: 10'd100};
                    default: ph = '{lit: 1'b0, ms: '0};
                endcase
            end
            PAT_ACTIVE_B: begin
                case (idx)
                    3'd0, 3'd2: ph = '{lit: 1'b1, ms: 10'd360};
                    3'd1:       ph = '{lit: 1'b0, ms: 10'd70};
                    3'd3:       ph = '{lit: 1'b0, ms: 10'd210};
                    default:    ph = '{lit: 1'b0, ms: '0};
                endcase
            end
            PAT_ALERT: begin
                case (idx)
                    3'd0, 3'd2, 3'd4: ph = '{lit: 1'b1, ms: 10'd50};
                    3'd1, 3'd3:       ph = '{lit: 1'b0, ms: 10'd50};
                    3'd5:             ph = '{lit: 1'b0, ms: 10'd250};
                    default:          ph = '{lit: 1'b0, ms: '0};
                endcase
            end
            default: begin
                // waiting pattern, also used for codes without a pattern
                case (idx)
                    3'd0:    ph = '{lit: 1'b1, ms: 10'd80};
                    3'd1:    ph = '{lit: 1'b0, ms: 10'd920};
                    default: ph = '{lit: 1'b0, ms: '0};
                endcase
            end
        endcase
        return ph;
    endfunction

    // Undefined modes play the waiting pattern
    function automatic logic [PATTERN_W-1:0] base_pattern(input logic [MODE_W-1:0] mode);
        return (mode <= PAT_ACTIVE_B) ? mode : PAT_WAITING;
    endfunction

endpackage

/* sv/lbps_cfg.sv */
// ----------------------------------------------------------------------------
// lbps_cfg
// APB register file holding the alert length.
// ----------------------------------------------------------------------------
module lbps_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lbps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lbps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lbps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [lbps_pkg::ALERT_W-1:0]        o_alert_len
);

    logic [lbps_pkg::ALERT_W-1:0]   r_alert_len;
    logic [lbps_pkg::ALERT_W-1:0]   n_alert_len;
    logic [lbps_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[lbps_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Decode the write request
    always_comb begin
        n_alert_len = r_alert_len;
        if (wr_en && (reg_idx == lbps_pkg::REG_ALERT_LEN)) begin
            n_alert_len = pwdata[lbps_pkg::ALERT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert_len <= lbps_pkg::ALERT_LEN_RESET;
        end else begin
            r_alert_len <= n_alert_len;
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (reg_idx == lbps_pkg::REG_ALERT_LEN) begin
            prdata = {{(lbps_pkg::APB_DATA_W-lbps_pkg::ALERT_W){1'b0}}, r_alert_len};
        end
    end

    assign o_alert_len = r_alert_len;

endmodule

/* sv/lbps_core.sv */
// ----------------------------------------------------------------------------
// lbps_core
// Sequencer state and single-pass next-state logic for one request.
// ----------------------------------------------------------------------------
module lbps_core #(
    parameter int MAX_PHASES = lbps_pkg::MAX_PHASES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  lbps_pkg::t_in_item            i_item,
    input  logic [lbps_pkg::ALERT_W-1:0]  i_alert_len,
    output lbps_pkg::t_out_item           o_result
);

    localparam int LEN_CAP_I = (MAX_PHASES > 8) ? 8 : ((MAX_PHASES < 1) ? 1 : MAX_PHASES);
    localparam logic [lbps_pkg::PHASE_CNT_W-1:0] LEN_CAP = LEN_CAP_I[lbps_pkg::PHASE_CNT_W-1:0];

    logic [lbps_pkg::MODE_W-1:0]    r_base_mode,  n_base_mode;
    logic [lbps_pkg::PATTERN_W-1:0] r_pattern,    n_pattern;
    logic [lbps_pkg::PHASE_W-1:0]   r_phase,      n_phase;
    logic [lbps_pkg::PH_TIME_W-1:0] r_ph_time,    n_ph_time;
    logic [lbps_pkg::ALERT_W-1:0]   r_alert_time, n_alert_time;
    logic                           r_led,        n_led;

    logic [lbps_pkg::ALERT_W-1:0]     alert_dec;
    logic [lbps_pkg::PATTERN_W-1:0]   wanted;
    logic [lbps_pkg::PH_TIME_W-1:0]   ph_time_dec;
    logic [lbps_pkg::PHASE_CNT_W-1:0] pat_len;
    logic [lbps_pkg::PHASE_CNT_W-1:0] next_cnt;
    logic [lbps_pkg::PHASE_W-1:0]     next_phase;
    lbps_pkg::t_phase                 step_ph;
    lbps_pkg::t_phase                 start_ph;
    lbps_pkg::t_phase                 mode_ph;
    lbps_pkg::t_phase                 alert_ph;
    logic [lbps_pkg::PATTERN_W-1:0]   mode_pat;

    // Timer countdowns and the pattern a tick wants
    assign alert_dec   = (r_alert_time != '0) ? r_alert_time - 1'b1 : '0;
    assign wanted      = (alert_dec != '0) ? lbps_pkg::PAT_ALERT
                                           : lbps_pkg::base_pattern(r_base_mode);
    assign ph_time_dec = (r_ph_time != '0) ? r_ph_time - 1'b1 : '0;

    // Wrap the phase at the end of the (capped) pattern
    assign pat_len    = (lbps_pkg::pat_count(r_pattern) < LEN_CAP)
                        ? lbps_pkg::pat_count(r_pattern) : LEN_CAP;
    assign next_cnt   = {1'b0, r_phase} + 1'b1;
    assign next_phase = (next_cnt >= pat_len) ? '0 : next_cnt[lbps_pkg::PHASE_W-1:0];

    // Table lookups
    assign step_ph  = lbps_pkg::phase_entry(r_pattern, next_phase);
    assign start_ph = lbps_pkg::phase_entry(wanted, '0);
    assign mode_pat = lbps_pkg::base_pattern(i_item.mode);
    assign mode_ph  = lbps_pkg::phase_entry(mode_pat, '0);
    assign alert_ph = lbps_pkg::phase_entry(lbps_pkg::PAT_ALERT, '0);

    // Apply one request
    always_comb begin
        n_base_mode  = r_base_mode;
        n_pattern    = r_pattern;
        n_phase      = r_phase;
        n_ph_time    = r_ph_time;
        n_alert_time = r_alert_time;
        n_led        = r_led;
        case (lbps_pkg::t_opcode'(i_item.opcode))
            lbps_pkg::OP_TICK: begin
                n_alert_time = alert_dec;
                if (wanted != r_pattern) begin
                    n_pattern = wanted;
                    n_phase   = '0;
                    n_led     = start_ph.lit;
                    n_ph_time = start_ph.ms;
                end else if (ph_time_dec == '0) begin
                    n_phase   = next_phase;
                    n_led     = step_ph.lit;
                    n_ph_time = step_ph.ms;
                end else begin
                    n_ph_time = ph_time_dec;
                end
            end
            lbps_pkg::OP_SET_MODE: begin
                n_base_mode = i_item.mode;
                if (r_alert_time == '0) begin
                    n_pattern = mode_pat;
                    n_phase   = '0;
                    n_led     = mode_ph.lit;
                    n_ph_time = mode_ph.ms;
                end
            end
            lbps_pkg::OP_ALERT: begin
                n_alert_time = i_alert_len;
                n_pattern    = lbps_pkg::PAT_ALERT;
                n_phase      = '0;
                n_led        = alert_ph.lit;
                n_ph_time    = alert_ph.ms;
            end
            default: begin
                // unused opcode: hold everything
            end
        endcase
    end

    // Hold state between requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_mode  <= lbps_pkg::PAT_WAITING;
            r_pattern    <= lbps_pkg::PAT_WAITING;
            r_phase      <= '0;
            r_ph_time    <= lbps_pkg::RESET_PH_TIME;
            r_alert_time <= '0;
            r_led        <= 1'b1;
        end else if (i_step) begin
            r_base_mode  <= n_base_mode;
            r_pattern    <= n_pattern;
            r_phase      <= n_phase;
            r_ph_time    <= n_ph_time;
            r_alert_time <= n_alert_time;
            r_led        <= n_led;
        end
    end

    // Result reflects the state after the request
    assign o_result.led_on        = n_led;
    assign o_result.shown_pattern = n_pattern;
    assign o_result.phase_number  = n_phase;
    assign o_result.alert_active  = (n_alert_time != '0);

endmodule

/* sv/led_blink_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer
// Plays fixed on/off phase tables on one status LED, with an overflow alert
// pattern that overrides the base mode for a programmable number of ticks.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                       | payload
//  ---------+-----------+---------------------------------+-----------------
//  in       | input     | i_in_valid / o_in_stall         | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall       | o_out_item (t_out_item)
//  cfg      | input     | psel, penable, pwrite / pready  | paddr, pwdata, prdata
//
// One request per cycle sustained while the output is not stalled; each result
// passes through the input register, then the result register.
// The state update is a single pass through table lookups and two countdowns.
// Synchronous active-low reset returns the waiting pattern, first phase lit,
// alert length 1500. A stalled output holds the result register and the
// input register; the input stalls only when both are full and the output
// is stalled.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer #(
    parameter int MAX_PHASES = lbps_pkg::MAX_PHASES_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  lbps_pkg::t_in_item               i_in_item,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output lbps_pkg::t_out_item              o_out_item,
    input  logic                             i_out_stall,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    logic                         r_in_valid;
    lbps_pkg::t_in_item           r_in_item;
    logic                         r_out_valid;
    lbps_pkg::t_out_item          r_out_item;
    logic                         out_free;
    logic                         in_take;
    logic                         step;
    logic [lbps_pkg::ALERT_W-1:0] alert_len;
    lbps_pkg::t_out_item          result;

    lbps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_alert_len (alert_len)
    );

    lbps_core #(
        .MAX_PHASES (MAX_PHASES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in_item),
        .i_alert_len (alert_len),
        .o_result    (result)
    );

    // Handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register: load a new request, drop it once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register: advance whenever the output side is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* tb/sv/tb_led_blink_pattern_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_blink_pattern_sequencer
// Self-checking bench for the LED blink pattern sequencer. A request queue
// feeds a clocked driver with random gaps. A clocked monitor stalls at random
// and compares every result with the LED state that a local model of the
// phase tables and both countdowns predicts. The alert length is reprogrammed
// between phases over the APB port, including zero, minimum and maximum.
// ----------------------------------------------------------------------------
module tb_led_blink_pattern_sequencer;
    import lbps_pkg::*;

    localparam int SEQ_MAX_PHASES = MAX_PHASES_DEFAULT;
    localparam int PHASE_LIMIT    = (SEQ_MAX_PHASES > 8) ? 8 :
                                    ((SEQ_MAX_PHASES < 1) ? 1 : SEQ_MAX_PHASES);
    localparam int MAX_WAIT       = 13;
    localparam int BOGUS_REG_IDX  = 1;

    localparam logic [MODE_W-1:0] MODE_WAITING  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE_A   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE_B   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ACTIVE_A = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ACTIVE_B = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ALL_ONES = 3'd7;

    // Phase tables: one row per pattern, entry = {lit, duration in ms}
    localparam logic [0:5][0:7][10:0] PHASE_TABLE = {
        {1'b1, 10'd80},  {1'b0, 10'd920}, {6{11'd0}},
        {1'b1, 10'd70},  {1'b0, 10'd130}, {1'b1, 10'd70},  {1'b0, 10'd730},
        {4{11'd0}},
        {1'b1, 10'd70},  {1'b0, 10'd100}, {1'b1, 10'd70},  {1'b0, 10'd100},
        {1'b1, 10'd70},  {1'b0, 10'd590}, {2{11'd0}},
        {1'b1, 10'd900}, {1'b0, 10'd100}, {6{11'd0}},
        {1'b1, 10'd360}, {1'b0, 10'd70},  {1'b1, 10'd360}, {1'b0, 10'd210},
        {4{11'd0}},
        {1'b1, 10'd50},  {1'b0, 10'd50},  {1'b1, 10'd50},  {1'b0, 10'd50},
        {1'b1, 10'd50},  {1'b0, 10'd250}, {2{11'd0}}
    };
    localparam logic [0:5][3:0] PATTERN_PHASES = {4'd2, 4'd4, 4'd6, 4'd2, 4'd4, 4'd6};

    // Clock, reset and DUT ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in_item              in_req      = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  out_stall   = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted sequencer state
    logic [MODE_W-1:0]    base_mode;
    logic [PATTERN_W-1:0] playing;
    logic [PHASE_W-1:0]   phase_idx;
    logic [PH_TIME_W-1:0] phase_left;
    logic [ALERT_W-1:0]   alert_left;
    logic                 led_level;
    logic [ALERT_W-1:0]   alert_len;

    t_in_item    request_q[$];
    t_out_item   led_state_q[$];
    int unsigned mismatch_cnt = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    bit          sender_quiet = 1'b0;
    bit          receiver_quiet = 1'b0;

    led_blink_pattern_sequencer #(
        .MAX_PHASES (SEQ_MAX_PHASES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Load one phase of the playing pattern
    function automatic void enter_phase(input int unsigned idx);
        logic [10:0] entry;
        entry      = PHASE_TABLE[playing][idx];
        phase_idx  = PHASE_W'(idx);
        led_level  = entry[10];
        phase_left = entry[PH_TIME_W-1:0];
    endfunction

    // Undefined modes fall back to the waiting pattern
    function automatic logic [PATTERN_W-1:0] pattern_of_mode(input logic [MODE_W-1:0] m);
        return (m <= MODE_ACTIVE_B) ? PATTERN_W'(m) : PAT_WAITING;
    endfunction

    // Apply one request to the predicted state and return the LED state after it
    function automatic t_out_item advance_sequencer(input t_in_item req);
        logic [PATTERN_W-1:0] wanted;
        int unsigned          next_idx;
        t_out_item            res;
        case (t_opcode'(req.opcode))
            OP_TICK: begin
                if (alert_left != 0) alert_left = alert_left - 1'b1;
                wanted = (alert_left != 0) ? PAT_ALERT : pattern_of_mode(base_mode);
                if (wanted != playing) begin
                    playing = wanted;
                    enter_phase(0);
                end else begin
                    if (phase_left != 0) phase_left = phase_left - 1'b1;
                    if (phase_left == 0) begin
                        next_idx = phase_idx + 1;
                        if (next_idx >= PATTERN_PHASES[playing] || next_idx >= PHASE_LIMIT)
                            next_idx = 0;
                        enter_phase(next_idx);
                    end
                end
            end
            OP_SET_MODE: begin
                base_mode = req.mode;
                if (alert_left == 0) begin
                    playing = pattern_of_mode(base_mode);
                    enter_phase(0);
                end
            end
            OP_ALERT: begin
                alert_left = alert_len;
                playing    = PAT_ALERT;
                enter_phase(0);
            end
            default: ;
        endcase
        res.led_on        = led_level;
        res.shown_pattern = playing;
        res.phase_number  = phase_idx;
        res.alert_active  = (alert_left != 0);
        return res;
    endfunction

    function automatic int unsigned draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Request driver: predict on acceptance, then present the next request
    always @(posedge i_clk) begin : drive_requests
        logic taken;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && !o_in_stall;
            if (taken) begin
                led_state_q.push_back(advance_sequencer(in_req));
                if ($urandom_range(0, 31) == 0) sender_quiet = !sender_quiet;
            end
            if (in_valid && !taken) begin
                // hold the stalled request
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                in_req   <= request_q.pop_front();
                in_valid <= 1'b1;
                gap_left = draw_wait(sender_quiet);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check against the oldest prediction, then stall at random
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (led_state_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: result %p with no request outstanding", o_out_item);
                end else begin
                    want = led_state_q.pop_front();
                    if (o_out_item.led_on        !== want.led_on        ||
                        o_out_item.shown_pattern !== want.shown_pattern ||
                        o_out_item.phase_number  !== want.phase_number  ||
                        o_out_item.alert_active  !== want.alert_active) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("ERROR: led %0b/%0b pattern %0d/%0d phase %0d/%0d alert %0b/%0b (exp/act)",
                                     want.led_on, o_out_item.led_on,
                                     want.shown_pattern, o_out_item.shown_pattern,
                                     want.phase_number, o_out_item.phase_number,
                                     want.alert_active, o_out_item.alert_active);
                    end
                end
                if ($urandom_range(0, 31) == 0) receiver_quiet = !receiver_quiet;
                stall_left = draw_wait(receiver_quiet);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_request(input t_opcode op, input logic [MODE_W-1:0] m);
        t_in_item req;
        req.opcode = op;
        req.mode   = m;
        request_q.push_back(req);
    endtask

    // Commands followed by tick runs, some long enough to step through phases
    task automatic queue_random_phase(input int unsigned count);
        int unsigned queued;
        int unsigned run;
        int unsigned pick;
        queued = 0;
        while (queued < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                queue_request(OP_SET_MODE, MODE_W'($urandom_range(0, 7)));
            else if (pick < 90)
                queue_request(OP_ALERT, MODE_W'($urandom_range(0, 7)));
            else
                queue_request(OP_UNUSED, MODE_W'($urandom_range(0, 7)));
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 40);
            repeat (run) queue_request(OP_TICK, MODE_W'($urandom_range(0, 7)));
            queued += run + 1;
        end
    endtask

    // Hold until every request is sent and every result has arrived
    task automatic wait_drained();
        while (request_q.size() != 0 || in_valid || led_state_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, register written at the access edge
    task automatic write_reg(input int idx, input logic [APB_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ALERT_LEN) alert_len = value[ALERT_W-1:0];
    endtask

    // Stimulus and end of test
    initial begin
        alert_len  = ALERT_LEN_RESET;
        base_mode  = MODE_WAITING;
        alert_left = '0;
        playing    = PAT_WAITING;
        enter_phase(0);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every mode, unused opcode, alert restart and mode change under alert
        queue_request(OP_TICK, MODE_ALL_ONES);
        queue_request(OP_SET_MODE, MODE_IDLE_A);
        queue_request(OP_SET_MODE, MODE_IDLE_B);
        queue_request(OP_SET_MODE, MODE_ACTIVE_A);
        queue_request(OP_SET_MODE, MODE_ACTIVE_B);
        queue_request(OP_SET_MODE, 3'd5);
        queue_request(OP_SET_MODE, 3'd6);
        queue_request(OP_SET_MODE, MODE_ALL_ONES);
        queue_request(OP_SET_MODE, MODE_WAITING);
        queue_request(OP_UNUSED, MODE_ALL_ONES);
        queue_request(OP_UNUSED, MODE_WAITING);
        queue_request(OP_ALERT, MODE_WAITING);
        queue_request(OP_TICK, MODE_WAITING);
        queue_request(OP_SET_MODE, MODE_ACTIVE_A);
        queue_request(OP_TICK, MODE_WAITING);
        queue_request(OP_UNUSED, MODE_IDLE_B);
        queue_request(OP_ALERT, MODE_ALL_ONES);
        queue_request(OP_TICK, MODE_WAITING);
        wait_drained();

        // Zero alert length: alert pattern starts but the base returns at once
        write_reg(REG_ALERT_LEN, 32'd0);
        queue_request(OP_ALERT, MODE_WAITING);
        queue_request(OP_TICK, MODE_WAITING);
        queue_request(OP_ALERT, MODE_WAITING);
        queue_request(OP_SET_MODE, MODE_IDLE_B);
        wait_drained();

        // Shortest alert; a write to an unmapped register must not change it
        write_reg(REG_ALERT_LEN, 32'd1);
        write_reg(BOGUS_REG_IDX, 32'hFFFF_FFFF);
        queue_random_phase(260);
        wait_drained();

        write_reg(REG_ALERT_LEN, 32'd4095);
        queue_random_phase(260);
        wait_drained();

        write_reg(REG_ALERT_LEN, $urandom_range(2, 200));
        queue_random_phase(260);
        wait_drained();

        write_reg(REG_ALERT_LEN, $urandom_range(2, 4094));
        queue_random_phase(260);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && led_state_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/lbps_pkg.sv
sv/lbps_cfg.sv
sv/lbps_core.sv
sv/led_blink_pattern_sequencer.sv
tb/sv/tb_led_blink_pattern_sequencer.sv
